/* rtl/spline_channel_interpolator_defines.svh */
// Assertion macros for the spline channel interpolator.
// Taken in by the top level, which supplies clk and arst_n in scope.
`ifndef SPLINE_CHANNEL_INTERPOLATOR_DEFINES_SVH
`define SPLINE_CHANNEL_INTERPOLATOR_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define SCI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define SCI_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/sci_pkg.sv */
// Shared constants for the spline channel interpolator.
// No dependencies; imported by spline_channel_interpolator.
package sci_pkg;

	// Field widths fixed by the interface.
	localparam int VALUE_W     = 32;
	localparam int CMD_W       = 2;
	localparam int INDEX_W     = 6;
	localparam int BAD_INDEX_W = 5;
	localparam int GOOD_CNT_W  = 7;
	localparam int BAD_CNT_W   = 6;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	// Fixed-point format and accumulator width.
	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 64;

	// Default sizes.
	localparam int DEF_MAX_GOOD   = 64;
	localparam int DEF_MAX_BAD    = 32;
	localparam int DEF_DATA_WIDTH = 32;

	// Reset values of the configuration registers.
	localparam logic [GOOD_CNT_W-1:0] GOOD_COUNT_RST = 7'd64;
	localparam logic [BAD_CNT_W-1:0]  BAD_COUNT_RST  = 6'd1;

	// Input command codes.
	localparam logic [CMD_W-1:0] CMD_LOAD_INV = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_SPL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd2;

	// Register select, taken from paddr bit 2.
	localparam logic REG_GOOD_COUNT = 1'b0;
	localparam logic REG_BAD_COUNT  = 1'b1;

endpackage

/* rtl/spline_channel_interpolator.sv */
// Spline channel interpolator top level: coefficient stores, sequencer and shared MAC.
// Depends on sci_pkg and spline_channel_interpolator_defines.svh.
`include "spline_channel_interpolator_defines.svh"

// Spherical-spline interpolation of bad channels from good-channel samples, in
// signed Q16.16. Load transactions fill the inverse matrix (command 0) and the
// bad-by-good spline matrix (command 1); sample transactions (command 2) fill one
// good-channel slot each. A sample marked end_of_row starts the row computation,
// t = inverse * samples and then y = spline * t, on a single shared
// multiply-accumulate unit that completes one product per cycle, except in the
// drain between the passes and while the result register is stalled, out of
// synchronous single-port memories. in_ready is low while a row is computed.
// One result per bad channel is delivered in order, the last flagged, and
// saturated is set when y or any t element of the row was clipped.
// The stores hold no reset value: every entry used must be loaded first.
module spline_channel_interpolator #(
	parameter int MAX_GOOD   = sci_pkg::DEF_MAX_GOOD,
	parameter int MAX_BAD    = sci_pkg::DEF_MAX_BAD,
	parameter int DATA_WIDTH = sci_pkg::DEF_DATA_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration port.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sci_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [sci_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [sci_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready,
	// Input channel.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [sci_pkg::CMD_W-1:0]            command,
	input  logic [sci_pkg::INDEX_W-1:0]          row_index,
	input  logic [sci_pkg::INDEX_W-1:0]          col_index,
	input  logic signed [sci_pkg::VALUE_W-1:0]   value,
	input  logic                                 end_of_row,
	// Output channel.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sci_pkg::BAD_INDEX_W-1:0]      bad_index,
	output logic signed [sci_pkg::VALUE_W-1:0]   imputed,
	output logic                                 saturated,
	output logic                                 last
);
	import sci_pkg::*;

	// Derived sizes.
	localparam int RMAX = (MAX_GOOD > MAX_BAD) ? MAX_GOOD : MAX_BAD;
	localparam int GI   = $clog2(MAX_GOOD);
	localparam int GW   = $clog2(MAX_GOOD + 1);
	localparam int RI   = $clog2(RMAX);
	localparam int LW   = $clog2(RMAX + 1);
	localparam int IAW  = $clog2(MAX_GOOD * MAX_GOOD);
	localparam int SAW  = (MAX_BAD * MAX_GOOD > 1) ? $clog2(MAX_BAD * MAX_GOOD) : 1;
	localparam int OPW  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int PW   = VALUE_W + OPW;

	localparam logic signed [ACC_W-1:0] CLAMP_HI =
		(64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [ACC_W-1:0] CLAMP_LO = -CLAMP_HI - 64'sd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TPASS,
		ST_DRAIN,
		ST_YPASS,
		ST_FLUSH
	} state_t;

	// Control tag that travels with each product down the MAC pipeline.
	typedef struct packed {
		logic          valid;
		logic          ph_y;
		logic          first;
		logic          last;
		logic          zero;
		logic [RI-1:0] row;
	} tag_t;

	// Configuration registers.
	logic [GOOD_CNT_W-1:0] good_count_q;
	logic [BAD_CNT_W-1:0]  bad_count_q;

	// Sequencer.
	state_t        state_q;
	logic [RI-1:0] i_q;
	logic [GI-1:0] k_q;
	logic [GW-1:0] g_q;
	logic [LW-1:0] b_q;
	logic [LW-1:0] row_lim_q;
	logic          tclip_q;

	// Output register.
	logic                    out_valid_q;
	logic [BAD_INDEX_W-1:0]  out_index_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                    out_sat_q;
	logic                    out_last_q;

	// Memories.
	logic signed [VALUE_W-1:0]    inv_mem  [MAX_GOOD*MAX_GOOD];
	logic signed [VALUE_W-1:0]    spl_mem  [MAX_BAD*MAX_GOOD];
	logic signed [VALUE_W-1:0]    samp_mem [MAX_GOOD];
	logic signed [DATA_WIDTH-1:0] part_mem [MAX_GOOD];

	// Pipeline.
	tag_t                         tag_s0, tag_s1, tag_s2, tag_s3;
	logic signed [VALUE_W-1:0]    inv_rd_s1, spl_rd_s1, samp_rd_s1;
	logic signed [DATA_WIDTH-1:0] part_rd_s1;
	logic [ACC_W-1:0]             prod_s2;
	logic [ACC_W-1:0]             acc_q;

	logic                      in_acc, cfg_wr, adv, pipe_busy, fin_t, fin_y;
	logic                      start_row, k_last, i_last;
	logic [IAW-1:0]            inv_raddr, inv_waddr;
	logic [SAW-1:0]            spl_raddr, spl_waddr;
	logic [GW-1:0]             g_eff;
	logic [LW-1:0]             b_eff;
	logic signed [VALUE_W-1:0] coef_sel;
	logic signed [OPW-1:0]     opnd_sel;
	logic signed [PW-1:0]      mult_full;
	logic signed [ACC_W-1:0]   acc_sh, acc_clamped;
	logic                      acc_clip;

	// Handshakes and register access.
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign start_row = in_acc && (command == CMD_SAMPLE) && end_of_row;
	assign prdata    = (paddr[2] == REG_BAD_COUNT) ? APB_DATA_W'(bad_count_q)
	                                               : APB_DATA_W'(good_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_count_q <= GOOD_COUNT_RST;
			bad_count_q  <= BAD_COUNT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_BAD_COUNT) begin
				bad_count_q <= pwdata[BAD_CNT_W-1:0];
			end else begin
				good_count_q <= pwdata[GOOD_CNT_W-1:0];
			end
		end
	end

	// Effective counts: good limited to the store size, bad clamped to 1 .. MAX_BAD.
	always_comb begin
		g_eff = (32'(good_count_q) > MAX_GOOD) ? GW'(MAX_GOOD) : GW'(good_count_q);
		if (bad_count_q == '0) begin
			b_eff = LW'(1);
		end else if (32'(bad_count_q) > MAX_BAD) begin
			b_eff = LW'(MAX_BAD);
		end else begin
			b_eff = LW'(bad_count_q);
		end
	end

	// Load addresses are row-major with a row pitch of MAX_GOOD.
	assign inv_waddr = IAW'(IAW'(row_index) * IAW'(MAX_GOOD) + IAW'(col_index));
	assign spl_waddr = SAW'(SAW'(row_index) * SAW'(MAX_GOOD) + SAW'(col_index));
	assign inv_raddr = IAW'(IAW'(i_q) * IAW'(MAX_GOOD) + IAW'(k_q));
	assign spl_raddr = SAW'(SAW'(i_q) * SAW'(MAX_GOOD) + SAW'(k_q));

	// Inner and outer loop ends of the issue counters.
	assign k_last = (g_q == '0) || ((GW'(k_q) + GW'(1)) == g_q);
	assign i_last = (LW'(i_q) + LW'(1)) == row_lim_q;

	// Issue stage tag.
	always_comb begin
		tag_s0.valid = (state_q == ST_TPASS) || (state_q == ST_YPASS);
		tag_s0.ph_y  = (state_q == ST_YPASS);
		tag_s0.first = (k_q == '0);
		tag_s0.last  = k_last;
		tag_s0.zero  = (g_q == '0);
		tag_s0.row   = i_q;
	end

	// Finishing a dot product: shift, clamp, and a stall when the result has no room.
	assign fin_t     = tag_s3.valid && tag_s3.last && !tag_s3.ph_y;
	assign fin_y     = tag_s3.valid && tag_s3.last && tag_s3.ph_y;
	assign adv       = !(fin_y && out_valid_q && !out_ready);
	assign pipe_busy = tag_s1.valid || tag_s2.valid || tag_s3.valid;

	always_comb begin
		acc_sh      = $signed(acc_q) >>> FRAC_BITS;
		acc_clip    = 1'b0;
		acc_clamped = acc_sh;
		if (acc_sh > CLAMP_HI) begin
			acc_clamped = CLAMP_HI;
			acc_clip    = 1'b1;
		end else if (acc_sh < CLAMP_LO) begin
			acc_clamped = CLAMP_LO;
			acc_clip    = 1'b1;
		end
	end

	// Sequencer, issue counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			k_q         <= '0;
			g_q         <= '0;
			b_q         <= LW'(1);
			row_lim_q   <= '0;
			tclip_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_value_q <= '0;
			out_sat_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_row) begin
						g_q     <= g_eff;
						b_q     <= b_eff;
						i_q     <= '0;
						k_q     <= '0;
						tclip_q <= 1'b0;
						if (g_eff == '0) begin
							row_lim_q <= b_eff;
							state_q   <= ST_YPASS;
						end else begin
							row_lim_q <= LW'(g_eff);
							state_q   <= ST_TPASS;
						end
					end
				end
				ST_TPASS, ST_YPASS: begin
					if (adv) begin
						if (k_last) begin
							k_q <= '0;
							if (i_last) begin
								state_q <= (state_q == ST_TPASS) ? ST_DRAIN : ST_FLUSH;
							end else begin
								i_q <= i_q + RI'(1);
							end
						end else begin
							k_q <= k_q + GI'(1);
						end
					end
				end
				ST_DRAIN: begin
					// The t vector must be fully written before y reads it.
					if (!pipe_busy) begin
						i_q       <= '0;
						k_q       <= '0;
						row_lim_q <= b_q;
						state_q   <= ST_YPASS;
					end
				end
				ST_FLUSH: begin
					if (!pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Clip of any t element marks every result of the row.
			if (fin_t && acc_clip) begin
				tclip_q <= 1'b1;
			end

			// Result register: loaded from a finished y, freed by its transaction.
			if (fin_y && adv) begin
				out_valid_q <= 1'b1;
				out_index_q <= BAD_INDEX_W'(tag_s3.row);
				out_value_q <= VALUE_W'(acc_clamped);
				out_sat_q   <= acc_clip || tclip_q;
				out_last_q  <= (LW'(tag_s3.row) + LW'(1)) == b_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign bad_index = out_index_q;
	assign imputed   = out_value_q;
	assign saturated = out_sat_q;
	assign last      = out_last_q;

	// Inverse matrix store.
	always_ff @(posedge clk) begin
		if (in_acc && (command == CMD_LOAD_INV) && (32'(row_index) < MAX_GOOD)
				&& (32'(col_index) < MAX_GOOD)) begin
			inv_mem[inv_waddr] <= value;
		end
		if (adv) begin
			inv_rd_s1 <= inv_mem[inv_raddr];
		end
	end

	// Spline matrix store.
	always_ff @(posedge clk) begin
		if (in_acc && (command == CMD_LOAD_SPL) && (32'(row_index) < MAX_BAD)
				&& (32'(col_index) < MAX_GOOD)) begin
			spl_mem[spl_waddr] <= value;
		end
		if (adv) begin
			spl_rd_s1 <= spl_mem[spl_raddr];
		end
	end

	// Sample slots of the current row.
	always_ff @(posedge clk) begin
		if (in_acc && (command == CMD_SAMPLE) && (32'(col_index) < MAX_GOOD)) begin
			samp_mem[GI'(col_index)] <= value;
		end
		if (adv) begin
			samp_rd_s1 <= samp_mem[k_q];
		end
	end

	// The t vector, written as each element finishes.
	always_ff @(posedge clk) begin
		if (fin_t && adv) begin
			part_mem[tag_s3.row[GI-1:0]] <= DATA_WIDTH'(acc_clamped);
		end
		if (adv) begin
			part_rd_s1 <= part_mem[k_q];
		end
	end

	// Shared multiplier: operand selection by pass.
	assign coef_sel  = tag_s1.ph_y ? spl_rd_s1 : inv_rd_s1;
	assign opnd_sel  = tag_s1.ph_y ? OPW'(part_rd_s1) : OPW'(samp_rd_s1);
	assign mult_full = coef_sel * opnd_sel;

	// Pipeline tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// Product register and accumulator, both wrapping at 64 bits.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= tag_s1.zero ? '0 : mult_full[ACC_W-1:0];
			if (tag_s2.valid) begin
				acc_q <= tag_s2.first ? prod_s2 : acc_q + prod_s2;
			end
		end
	end

	// Checks on the sequencer and the result path.
	`SCI_ASSERT(a_idle_pipe_empty, in_ready |-> !pipe_busy, "pipeline busy while accepting input")
	`SCI_NEVER(a_t_done_before_y, (state_q == ST_YPASS) && tag_s3.valid && !tag_s3.ph_y, "t still in flight during y pass")
	`SCI_ASSERT(a_last_is_final_bad, out_valid && last |-> bad_index == BAD_INDEX_W'(b_q - LW'(1)), "last flag on wrong bad channel")
	`SCI_ASSERT(a_acc_holds_on_stall, fin_y && out_valid && !out_ready |=> $stable(acc_q), "accumulator moved while result stalled")

endmodule

/* tb/sv/spline_imputation_checker.sv */
// Checker for the spline channel interpolator: tracks the register writes and
// the accepted transactions, predicts the imputed values of each row, compares.
// Depends on sci_pkg only.
module spline_imputation_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic                                 pready,
	input  logic [sci_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [sci_pkg::APB_DATA_W-1:0]       pwdata,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [sci_pkg::CMD_W-1:0]            command,
	input  logic [sci_pkg::INDEX_W-1:0]          row_index,
	input  logic [sci_pkg::INDEX_W-1:0]          col_index,
	input  logic signed [sci_pkg::VALUE_W-1:0]   value,
	input  logic                                 end_of_row,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic [sci_pkg::BAD_INDEX_W-1:0]      bad_index,
	input  logic signed [sci_pkg::VALUE_W-1:0]   imputed,
	input  logic                                 saturated,
	input  logic                                 last,
	output int                                   mismatch_count,
	output int                                   pending_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import sci_pkg::*;

	localparam int MAX_GOOD = DEF_MAX_GOOD;
	localparam int MAX_BAD  = DEF_MAX_BAD;
	localparam longint VALUE_MAX = (longint'(1) <<< (DEF_DATA_WIDTH - 1)) - 1;
	localparam longint VALUE_MIN = -VALUE_MAX - 1;

	typedef struct packed {
		logic [BAD_INDEX_W-1:0]     bad_index;
		logic signed [VALUE_W-1:0]  imputed;
		logic                       saturated;
		logic                       last;
	} imputation_t;

	// Shadow copy of the registers and the stores.
	logic [GOOD_CNT_W-1:0] good_count;
	logic [BAD_CNT_W-1:0]  bad_count;
	int inverse_coef [MAX_GOOD][MAX_GOOD];
	int spline_coef  [MAX_BAD][MAX_GOOD];
	int row_samples  [MAX_GOOD];
	imputation_t expected_imputations [$];

	function automatic longint clip_to_value(input longint v);
		if (v > VALUE_MAX)
			return VALUE_MAX;
		if (v < VALUE_MIN)
			return VALUE_MIN;
		return v;
	endfunction

	// Forms t = inverse * samples, then y = spline * t, and queues one result per bad channel.
	function automatic void predict_row_imputations();
		int g;
		int b;
		longint acc;
		longint y;
		longint y_clip;
		longint t_vec [MAX_GOOD];
		bit t_clipped;
		imputation_t res;
		g = (good_count > MAX_GOOD) ? MAX_GOOD : int'(good_count);
		b = (bad_count == 0) ? 1 : ((bad_count > MAX_BAD) ? MAX_BAD : int'(bad_count));
		t_clipped = 1'b0;
		for (int i = 0; i < g; i++) begin
			acc = 0;
			for (int k = 0; k < g; k++)
				acc += longint'(inverse_coef[i][k]) * longint'(row_samples[k]);
			t_vec[i] = clip_to_value(acc >>> FRAC_BITS);
			if (t_vec[i] != (acc >>> FRAC_BITS))
				t_clipped = 1'b1;
		end
		for (int j = 0; j < b; j++) begin
			acc = 0;
			for (int k = 0; k < g; k++)
				acc += longint'(spline_coef[j][k]) * t_vec[k];
			y = acc >>> FRAC_BITS;
			y_clip = clip_to_value(y);
			res.bad_index = BAD_INDEX_W'(j);
			res.imputed   = y_clip[VALUE_W-1:0];
			res.saturated = t_clipped || (y_clip != y);
			res.last      = (j == b - 1);
			expected_imputations = {expected_imputations, res};
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Watch the three ports at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		imputation_t want;
		if (!arst_n) begin
			good_count = GOOD_COUNT_RST;
			bad_count  = BAD_COUNT_RST;
			expected_imputations.delete();
			mismatch_count = 0;
			pending_results <= 0;
		end else begin
			// Register writes complete in the access phase.
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
					REG_GOOD_COUNT: good_count = pwdata[GOOD_CNT_W-1:0];
					REG_BAD_COUNT:  bad_count  = pwdata[BAD_CNT_W-1:0];
					default: ;
				endcase
			end

			// Each result transaction is compared against the oldest prediction.
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_imputations.size() == 0) begin
					report_mismatch($sformatf("result for bad channel %0d with none expected",
						bad_index));
				end else begin
					want = expected_imputations.pop_front();
					if (bad_index !== want.bad_index)
						report_mismatch($sformatf("bad_index %0d, expected %0d",
							bad_index, want.bad_index));
					if (imputed !== want.imputed)
						report_mismatch($sformatf("channel %0d imputed %0d, expected %0d",
							want.bad_index, imputed, $signed(want.imputed)));
					if (saturated !== want.saturated)
						report_mismatch($sformatf("channel %0d saturated %b, expected %b",
							want.bad_index, saturated, want.saturated));
					if (last !== want.last)
						report_mismatch($sformatf("channel %0d last %b, expected %b",
							want.bad_index, last, want.last));
				end
			end

			// Input transactions update the shadow stores; a row end triggers prediction.
			if (in_valid && in_ready) begin
				case (command)
					CMD_LOAD_INV: inverse_coef[row_index][col_index] = value;
					CMD_LOAD_SPL: begin
						if (row_index < MAX_BAD)
							spline_coef[row_index][col_index] = value;
					end
					CMD_SAMPLE: begin
						row_samples[col_index] = value;
						if (end_of_row)
							predict_row_imputations();
					end
					default: ;
				endcase
			end

			pending_results <= expected_imputations.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
// Top of the spline channel interpolator testbench: clock, reset, register
// writes, bursty input stimulus and output back-pressure, and the verdict.
// Depends on sci_pkg, spline_channel_interpolator and spline_imputation_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sci_pkg::*;

	localparam int MAX_GOOD       = DEF_MAX_GOOD;
	localparam int MAX_BAD        = DEF_MAX_BAD;
	localparam int SETTLE_CYCLES  = 32;
	localparam int RANDOM_ITEMS   = 200;
	localparam int RANDOM_RESULTS = 48;
	localparam int RUN_LIMIT_NS   = 40_000_000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]       paddr = '0;
	logic [APB_DATA_W-1:0]       pwdata = '0;
	logic [APB_DATA_W-1:0]       prdata;
	logic                        pready;

	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [CMD_W-1:0]            command = CMD_SAMPLE;
	logic [INDEX_W-1:0]          row_index = '0;
	logic [INDEX_W-1:0]          col_index = '0;
	logic signed [VALUE_W-1:0]   value = '0;
	logic                        end_of_row = 1'b0;

	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [BAD_INDEX_W-1:0]      bad_index;
	logic signed [VALUE_W-1:0]   imputed;
	logic                        saturated;
	logic                        last;

	int mismatches;
	int results_pending;

	// Which store entries the stimulus has written, so no unwritten entry is ever used.
	bit inv_loaded  [MAX_GOOD][MAX_GOOD];
	bit spl_loaded  [MAX_BAD][MAX_GOOD];
	bit slot_loaded [MAX_GOOD];
	int good_eff = MAX_GOOD;
	int bad_eff = 1;
	int burst_left = 0;
	int counted_items = 0;
	int results_due = 0;
	int unsigned rx_hold = 0;

	spline_channel_interpolator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.row_index  (row_index),
		.col_index  (col_index),
		.value      (value),
		.end_of_row (end_of_row),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bad_index  (bad_index),
		.imputed    (imputed),
		.saturated  (saturated),
		.last       (last)
	);

	spline_imputation_checker imputation_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.row_index       (row_index),
		.col_index       (col_index),
		.value           (value),
		.end_of_row      (end_of_row),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bad_index       (bad_index),
		.imputed         (imputed),
		.saturated       (saturated),
		.last            (last),
		.mismatch_count  (mismatches),
		.pending_results (results_pending)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure: alternating ready and stall stretches of random length.
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			out_ready <= !out_ready;
			if (out_ready)
				rx_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
			else
				rx_hold <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
		end
	end

	// Tame values stay within plus or minus 4.0 so that rows mostly do not saturate.
	function automatic logic [VALUE_W-1:0] pick_value(input bit wild);
		int tame;
		tame = int'($urandom_range(0, 524288)) - 262144;
		if (!wild)
			return tame;
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom();
			3: return 32'hFFFF_FFFF;
			default: return tame;
		endcase
	endfunction

	// One input transaction, preceded by a random gap at the start of each burst.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input int row, input int col,
			input logic [VALUE_W-1:0] val, input logic eor);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		command    <= cmd;
		row_index  <= INDEX_W'(row);
		col_index  <= INDEX_W'(col);
		value      <= val;
		end_of_row <= eor;
		do @(posedge clk); while (in_ready !== 1'b1);
		case (cmd)
			CMD_LOAD_INV: begin
				inv_loaded[row][col] = 1'b1;
				counted_items++;
			end
			CMD_LOAD_SPL: begin
				if (row < MAX_BAD) begin
					spl_loaded[row][col] = 1'b1;
					counted_items++;
				end
			end
			CMD_SAMPLE: begin
				slot_loaded[col] = 1'b1;
				counted_items++;
			end
			default: ;
		endcase
	endtask

	// Drop valid and wait until every predicted result has been delivered.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Register writes happen only once the block has gone idle.
	task automatic set_counts(input int good, input int bad);
		wait_idle();
		apb_write({REG_GOOD_COUNT, 2'b00}, good);
		apb_write({REG_BAD_COUNT, 2'b00}, bad);
		good_eff = (good > MAX_GOOD) ? MAX_GOOD : good;
		bad_eff = (bad == 0) ? 1 : ((bad > MAX_BAD) ? MAX_BAD : bad);
	endtask

	// Fill every entry the coming row reads that has never been written.
	task automatic load_missing(input int final_col);
		for (int i = 0; i < good_eff; i++)
			for (int k = 0; k < good_eff; k++)
				if (!inv_loaded[i][k])
					send_item(CMD_LOAD_INV, i, k, pick_value(1'b0), $urandom_range(0, 7) == 0);
		for (int j = 0; j < bad_eff; j++)
			for (int k = 0; k < good_eff; k++)
				if (!spl_loaded[j][k])
					send_item(CMD_LOAD_SPL, j, k, pick_value(1'b0), $urandom_range(0, 7) == 0);
		for (int k = 0; k < good_eff; k++)
			if (k != final_col && !slot_loaded[k])
				send_item(CMD_SAMPLE, $urandom_range(0, 63), k, pick_value(1'b0), 1'b0);
	endtask

	// A time row: a few stray transactions, samples for a random subset of slots,
	// then the closing sample marked end_of_row.
	task automatic send_row(input bit wild);
		int final_col;
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 5))
				0, 1: send_item(CMD_LOAD_INV, $urandom_range(0, 63), $urandom_range(0, 63),
					pick_value(wild), $urandom_range(0, 7) == 0);
				2, 3: send_item(CMD_LOAD_SPL, $urandom_range(0, 63), $urandom_range(0, 63),
					pick_value(wild), $urandom_range(0, 7) == 0);
				4: send_item(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom(), $urandom_range(0, 1) == 1);
				default: send_item(CMD_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 63),
					pick_value(wild), 1'b0);
			endcase
		end
		final_col = (good_eff == 0) ? $urandom_range(0, 63) : $urandom_range(0, good_eff - 1);
		for (int k = 0; k < good_eff; k++)
			if (k != final_col && $urandom_range(0, 3) != 0)
				send_item(CMD_SAMPLE, $urandom_range(0, 63), k, pick_value(wild), 1'b0);
		load_missing(final_col);
		send_item(CMD_SAMPLE, $urandom_range(0, 63), final_col, pick_value(wild), 1'b1);
	endtask

	// Run limit, in case a result never arrives.
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two good and two bad channels with extreme coefficients and samples.
		set_counts(2, 2);
		send_item(CMD_UNUSED, 63, 63, 32'hFFFF_FFFF, 1'b1);
		send_item(CMD_LOAD_INV, 0, 0, 32'h7FFF_FFFF, 1'b1);
		send_item(CMD_LOAD_INV, 0, 1, 32'h8000_0000, 1'b0);
		send_item(CMD_LOAD_INV, 1, 0, 32'h0001_0000, 1'b0);
		send_item(CMD_LOAD_INV, 1, 1, 32'hFFFF_FFFF, 1'b0);
		send_item(CMD_LOAD_SPL, 0, 0, 32'h0001_0000, 1'b0);
		send_item(CMD_LOAD_SPL, 0, 1, 32'h8000_0000, 1'b0);
		send_item(CMD_LOAD_SPL, 1, 0, 32'h7FFF_FFFF, 1'b0);
		send_item(CMD_LOAD_SPL, 1, 1, 32'h0000_8000, 1'b0);
		// A spline row beyond the store is dropped.
		send_item(CMD_LOAD_SPL, 63, 0, 32'h1234_5678, 1'b0);
		// A slot above good_count is stored but takes no part.
		send_item(CMD_SAMPLE, 0, 63, 32'h7FFF_FFFF, 1'b0);
		send_item(CMD_SAMPLE, 0, 0, 32'h0000_0000, 1'b0);
		send_item(CMD_SAMPLE, 0, 1, 32'h0001_0000, 1'b1);
		send_item(CMD_SAMPLE, 0, 0, 32'h7FFF_FFFF, 1'b0);
		send_item(CMD_SAMPLE, 0, 1, 32'h8000_0000, 1'b1);
		// Slot one is not resent and keeps its previous value.
		send_item(CMD_SAMPLE, 5, 0, 32'h0002_0000, 1'b1);

		// Zero good channels give an empty sum; zero bad channels act as one.
		set_counts(0, 0);
		send_item(CMD_SAMPLE, 0, 0, 32'h0001_0000, 1'b1);

		set_counts(1, 1);
		send_row(1'b0);

		// Random phases, mostly small sizes; half of them reload the stores afresh.
		counted_items = 0;
		while (counted_items < RANDOM_ITEMS || results_due < RANDOM_RESULTS) begin
			if ($urandom_range(0, 1) == 0) begin
				for (int i = 0; i < MAX_GOOD; i++) begin
					slot_loaded[i] = 1'b0;
					for (int k = 0; k < MAX_GOOD; k++)
						inv_loaded[i][k] = 1'b0;
				end
				for (int j = 0; j < MAX_BAD; j++)
					for (int k = 0; k < MAX_GOOD; k++)
						spl_loaded[j][k] = 1'b0;
			end
			set_counts($urandom_range(1, 8),
				($urandom_range(0, 4) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8));
			repeat ($urandom_range(1, 3)) begin
				send_row($urandom_range(0, 3) == 0);
				results_due += bad_eff;
			end
		end

		// A bad count above range is clamped to the full set of bad channels.
		set_counts(1, 63);
		send_row(1'b0);

		wait_idle();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/sci_pkg.sv
rtl/spline_channel_interpolator.sv
tb/sv/spline_imputation_checker.sv
tb/sv/testbench.sv
